// ===== design/mhw_pkg.sv =====
// Shared constants and types for the memory headroom watermark block.
package mhw_pkg;

  localparam int BYTE_W    = 48;
  localparam int NUM_W     = BYTE_W + 1;
  localparam int DEV_W     = 3;
  localparam int DEV_COUNT = 8;
  localparam int OP_W      = 2;
  localparam int THR_W     = 7;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(90);
  localparam logic [THR_W-1:0] PCT       = THR_W'(100);

  localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
  localparam logic [OP_W-1:0] OP_PREDICT = 2'd1;
  localparam logic [OP_W-1:0] OP_RECORD  = 2'd2;

  // threshold products: numerator * 100 against threshold * total
  localparam int PROD_TH_W = NUM_W + THR_W;

  // cross-multiply split: numerator in two pieces, denominator in two pieces
  localparam int LO_X    = (NUM_W + 1) / 2;
  localparam int LO_Y    = (BYTE_W + 1) / 2;
  localparam int PROD_W  = LO_X + LO_Y;
  localparam int ACC_W   = NUM_W + BYTE_W + 2;
  localparam int STEP_W  = 3;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(7);

  typedef struct packed {
    logic [BYTE_W-1:0] prev_used;
    logic [BYTE_W-1:0] worst;
  } entry_t;

  localparam int ENTRY_W = 2 * BYTE_W;

endpackage

// ===== design/mhw_ram.sv =====
// Generic single-write, single-read RAM with registered read data (read-first).
module mhw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/memory_headroom_watermark.sv =====
// Top level of the memory headroom watermark: per-device state, ratio tracking, result.
//
// Input channel (in_valid/in_stall): snapshot elements of operation, device,
// used_bytes, total_bytes and last. A transfer happens on a rising edge with
// in_valid high and in_stall low. Output channel (out_valid/out_stall): one
// result per predict or record snapshot, sent with its last element.
// Configuration channel (cfg_valid/cfg_ready): writes threshold_pct; write it
// only while the block is idle. cfg_ready is always high.
// Throughput: one element per cycle. An element that passes the threshold
// while a running best already exists holds the input until the shared 25x24
// multiplier has made its eight passes to cross-multiply the ratios.
// A result passes the RAM read and growth update, the threshold products and
// the best update before its output register, and is held further by any compare.
// The result sits in an output register; elements keep flowing while it
// waits, and on the output side the input stalls only when a second result is
// ready in the best stage while the first is still stalled.
// Reset: synchronous; all devices become untracked, the running best clears
// and threshold_pct returns to 90. Per-device RAM contents need no clearing.
module memory_headroom_watermark (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [mhw_pkg::OP_W-1:0]   operation,
  input  logic [mhw_pkg::DEV_W-1:0]  device,
  input  logic [mhw_pkg::BYTE_W-1:0] used_bytes,
  input  logic [mhw_pkg::BYTE_W-1:0] total_bytes,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      found,
  output logic [mhw_pkg::DEV_W-1:0]  hit_device,
  output logic [mhw_pkg::NUM_W-1:0]  ratio_used,
  output logic [mhw_pkg::BYTE_W-1:0] ratio_total,
  output logic [mhw_pkg::BYTE_W-1:0] slot_growth,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mhw_pkg::THR_W-1:0]  threshold_pct
);
  import mhw_pkg::*;

  logic [THR_W-1:0] thr;
  logic             en;
  logic             accept;

  // stage 1: RAM data arrives
  logic              s1_valid;
  logic [OP_W-1:0]   s1_op;
  logic [DEV_W-1:0]  s1_dev;
  logic [BYTE_W-1:0] s1_used;
  logic [BYTE_W-1:0] s1_total;
  logic              s1_last;

  // stage 2: threshold products
  logic              s2_valid;
  logic              s2_emit;
  logic              s2_last;
  logic              s2_cand;
  logic [DEV_W-1:0]  s2_dev;
  logic [NUM_W-1:0]  s2_num;
  logic [BYTE_W-1:0] s2_den;
  logic [BYTE_W-1:0] s2_growth;

  // stage 3: best update
  logic                 s3_valid;
  logic                 s3_emit;
  logic                 s3_last;
  logic                 s3_cand;
  logic [DEV_W-1:0]     s3_dev;
  logic [NUM_W-1:0]     s3_num;
  logic [BYTE_W-1:0]    s3_den;
  logic [BYTE_W-1:0]    s3_growth;
  logic [PROD_TH_W-1:0] s3_pnum;
  logic [PROD_TH_W-1:0] s3_pthr;

  logic [DEV_COUNT-1:0] tracked;
  logic                 best_valid;
  logic [DEV_W-1:0]     best_dev;
  logic [NUM_W-1:0]     best_num;
  logic [BYTE_W-1:0]    best_den;
  logic [BYTE_W-1:0]    best_growth;

  // RAM and forwarding of the latest write
  entry_t            ram_rdata;
  entry_t            ram_wdata;
  logic              ram_we;
  logic              fwd_valid;
  logic [DEV_W-1:0]  fwd_dev;
  entry_t            fwd_data;
  entry_t            cur;

  logic              trk;
  logic              rise_gt;
  logic [BYTE_W-1:0] rise;
  logic [BYTE_W-1:0] worst_next;
  logic              s1_cand;
  logic [NUM_W-1:0]  s1_num;
  logic [BYTE_W-1:0] s1_growth;

  // compare unit
  logic              qualify;
  logic              need_cmp;
  logic              cmp_fin;
  logic [STEP_W-1:0] cmp_step;
  logic [ACC_W-1:0]  acc;
  logic [NUM_W-1:0]  x_op;
  logic [BYTE_W-1:0] y_op;
  logic [LO_X-1:0]   x_part;
  logic [LO_Y-1:0]   y_part;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  term;
  logic              better;
  logic              s3_done;
  logic              take;

  logic              bv_next;
  logic [DEV_W-1:0]  bd_next;
  logic [NUM_W-1:0]  bn_next;
  logic [BYTE_W-1:0] bden_next;
  logic [BYTE_W-1:0] bg_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_valid) begin
      thr <= threshold_pct;
    end
  end

  // hold the whole pipe while a compare runs or a result cannot leave
  assign s3_done  = !need_cmp || cmp_fin;
  assign en       = s3_done && !(s3_valid && s3_emit && out_valid && out_stall);
  assign in_stall = !en;
  assign accept   = in_valid && en;

  mhw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEV_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_dev),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (device),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= operation;
      s1_dev   <= device;
      s1_used  <= used_bytes;
      s1_total <= total_bytes;
      s1_last  <= last;
    end
  end

  // stage 1: growth update and candidate forming
  always_comb begin
    cur        = (fwd_valid && fwd_dev == s1_dev) ? fwd_data : ram_rdata;
    trk        = tracked[s1_dev];
    rise_gt    = s1_used > cur.prev_used;
    rise       = s1_used - cur.prev_used;
    worst_next = cur.worst;
    if (s1_total != '0 && rise_gt && rise > cur.worst) begin
      worst_next = rise;
    end
    s1_cand   = 1'b0;
    s1_num    = NUM_W'(s1_used);
    s1_growth = cur.worst;
    ram_we    = 1'b0;
    ram_wdata = '{prev_used: s1_used, worst: '0};
    unique case (s1_op)
      OP_INIT: begin
        ram_we = s1_valid && en;
      end
      OP_PREDICT: begin
        s1_cand = trk && s1_total != '0 && cur.worst != '0;
        s1_num  = NUM_W'(s1_used) + NUM_W'(cur.worst);
      end
      OP_RECORD: begin
        ram_we    = s1_valid && en && trk;
        ram_wdata = '{prev_used: s1_used, worst: worst_next};
        s1_cand   = trk && s1_total != '0;
        s1_growth = worst_next;
      end
      default: begin
        s1_cand = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracked   <= '0;
      fwd_valid <= 1'b0;
    end else begin
      if (ram_we) begin
        fwd_valid <= 1'b1;
      end
      if (s1_valid && en && s1_op == OP_INIT) begin
        tracked[s1_dev] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_dev  <= s1_dev;
      fwd_data <= ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_emit   <= s1_last && (s1_op == OP_PREDICT || s1_op == OP_RECORD);
      s2_last   <= s1_last;
      s2_cand   <= s1_cand;
      s2_dev    <= s1_dev;
      s2_num    <= s1_num;
      s2_den    <= s1_total;
      s2_growth <= s1_growth;

      s3_emit   <= s2_emit;
      s3_last   <= s2_last;
      s3_cand   <= s2_cand;
      s3_dev    <= s2_dev;
      s3_num    <= s2_num;
      s3_den    <= s2_den;
      s3_growth <= s2_growth;
      s3_pnum   <= PROD_TH_W'(s2_num) * PROD_TH_W'(PCT);
      s3_pthr   <= PROD_TH_W'(thr) * PROD_TH_W'(s2_den);
    end
  end

  // stage 3: threshold check, then cross-multiply against the running best
  assign qualify  = s3_pnum >= s3_pthr;
  assign need_cmp = s3_valid && s3_cand && qualify && best_valid;

  always_comb begin
    x_op   = cmp_step[2] ? best_num : s3_num;
    y_op   = cmp_step[2] ? s3_den : best_den;
    x_part = cmp_step[1] ? LO_X'(x_op[NUM_W-1:LO_X]) : x_op[LO_X-1:0];
    y_part = cmp_step[0] ? LO_Y'(y_op[BYTE_W-1:LO_Y]) : y_op[LO_Y-1:0];
    prod   = PROD_W'(x_part) * PROD_W'(y_part);
    unique case (cmp_step[1:0])
      2'b00:   term = ACC_W'(prod);
      2'b01:   term = ACC_W'(prod) << LO_Y;
      2'b10:   term = ACC_W'(prod) << LO_X;
      default: term = ACC_W'(prod) << (LO_X + LO_Y);
    endcase
  end

  // positive sum means candidate * best_den exceeds best_num * candidate_den
  assign better = !acc[ACC_W-1] && acc != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_fin  <= 1'b0;
      cmp_step <= '0;
      acc      <= '0;
    end else if (en) begin
      cmp_fin  <= 1'b0;
      cmp_step <= '0;
      acc      <= '0;
    end else if (need_cmp && !cmp_fin) begin
      acc      <= cmp_step[2] ? acc - term : acc + term;
      cmp_step <= cmp_step + STEP_W'(1);
      if (cmp_step == STEP_LAST) begin
        cmp_fin <= 1'b1;
      end
    end
  end

  assign take = s3_valid && s3_cand && qualify && (!best_valid || better);

  always_comb begin
    bv_next   = best_valid;
    bd_next   = best_dev;
    bn_next   = best_num;
    bden_next = best_den;
    bg_next   = best_growth;
    if (take) begin
      bv_next   = 1'b1;
      bd_next   = s3_dev;
      bn_next   = s3_num;
      bden_next = s3_den;
      bg_next   = s3_growth;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid  <= 1'b0;
      best_dev    <= '0;
      best_num    <= '0;
      best_den    <= '0;
      best_growth <= '0;
    end else if (en && s3_valid) begin
      if (s3_last) begin
        best_valid  <= 1'b0;
        best_dev    <= '0;
        best_num    <= '0;
        best_den    <= '0;
        best_growth <= '0;
      end else begin
        best_valid  <= bv_next;
        best_dev    <= bd_next;
        best_num    <= bn_next;
        best_den    <= bden_next;
        best_growth <= bg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && s3_valid && s3_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s3_valid && s3_emit) begin
      found       <= bv_next;
      hit_device  <= bd_next;
      ratio_used  <= bn_next;
      ratio_total <= bden_next;
      slot_growth <= bg_next;
    end
  end

  a_fin_has_item: assert property (@(posedge clk) disable iff (rst)
    cmp_fin |-> s3_valid)
    else $error("compare finished with no item in the best stage");

  a_cmp_holds_input: assert property (@(posedge clk) disable iff (rst)
    (need_cmp && !cmp_fin) |-> in_stall)
    else $error("input taken while a ratio compare runs");

  a_found_has_total: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> ratio_total != '0)
    else $error("reported device has zero capacity");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (ratio_used == '0 && hit_device == '0 && slot_growth == '0))
    else $error("empty result carries data");

  a_init_tracks: assert property (@(posedge clk) disable iff (rst)
    (en && s1_valid && s1_op == OP_INIT) |=> tracked[$past(s1_dev)])
    else $error("init transfer did not mark the device tracked");

endmodule
